@@ rtl/pga_pkg.sv @@
// ----------------------------------------------------------------------------
// pga_pkg
// Shared widths, constants and sideband types of the pairwise gravity block.
// ----------------------------------------------------------------------------
package pga_pkg;

    localparam int COORD_W    = 32;
    localparam int MASS_W     = 16;
    localparam int GRAV_W     = 16;
    localparam int IN_W       = 4 * COORD_W + MASS_W;
    localparam int MAG_W      = COORD_W + 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int ROOT_W     = (SUM_W + 1) / 2;
    localparam int R2_W       = 2 * ROOT_W;
    localparam int DEN_W      = 3 * ROOT_W;
    localparam int GM_W       = GRAV_W + MASS_W;
    localparam int PROD_W     = GM_W + MAG_W;
    localparam int FRAC_SHIFT = 48;
    localparam int NUM_W      = PROD_W + FRAC_SHIFT;
    localparam int QBITS      = COORD_W - 1;
    localparam int CMP_W      = DEN_W + QBITS + 1;

    localparam logic [GRAV_W-1:0]  GRAV_RESET = GRAV_W'(80);
    localparam logic [COORD_W-1:0] SAT_POS    = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_NEG    = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic               nx;
        logic               ny;
        logic               coinc;
        logic [MAG_W-1:0]   mx;
        logic [MAG_W-1:0]   my;
        logic [GM_W-1:0]    gm;
    } side_t;

    typedef struct packed {
        logic nx;
        logic ny;
        logic coinc;
    } sign_t;

endpackage

@@ rtl/pga_isqrt.sv @@
// ----------------------------------------------------------------------------
// pga_isqrt
// Pipelined integer square root, one root bit per stage, sideband carried.
// ----------------------------------------------------------------------------
module pga_isqrt
    import pga_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SUM_W-1:0]  in_sum,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output side_t             out_side
);

    logic              vld_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];
    logic [R2_W-1:0]   rem_reg  [0:ROOT_W];
    side_t             side_reg [0:ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            root_reg[0] <= '0;
            rem_reg[0]  <= R2_W'(in_sum);
            side_reg[0] <= in_side;
        end
    end

    for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
        localparam int B = ROOT_W - 1 - j;
        logic [R2_W-1:0]   trial;
        logic              take;
        logic [ROOT_W-1:0] root_next;
        logic [R2_W-1:0]   rem_next;

        always_comb begin
            trial     = (R2_W'(root_reg[j]) << (B + 1)) | (R2_W'(1) << (2 * B));
            take      = (trial <= rem_reg[j]);
            root_next = take ? (root_reg[j] | (ROOT_W'(1) << B)) : root_reg[j];
            rem_next  = take ? (rem_reg[j] - trial) : rem_reg[j];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[j+1] <= root_next;
                rem_reg[j+1]  <= rem_next;
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];

endmodule

@@ rtl/pga_div.sv @@
// ----------------------------------------------------------------------------
// pga_div
// Two-lane pipelined restoring divider with saturation and sign restore.
// ----------------------------------------------------------------------------
module pga_div
    import pga_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [DEN_W-1:0]   in_den,
    input  logic [PROD_W-1:0]  in_px,
    input  logic [PROD_W-1:0]  in_py,
    input  sign_t              in_sign,
    output logic               out_valid,
    output logic [COORD_W-1:0] accel_x,
    output logic [COORD_W-1:0] accel_y,
    output logic               coincident
);

    logic              vld_reg  [0:QBITS];
    logic [DEN_W-1:0]  den_reg  [0:QBITS];
    logic [NUM_W-1:0]  remx_reg [0:QBITS];
    logic [NUM_W-1:0]  remy_reg [0:QBITS];
    logic [QBITS-1:0]  qx_reg   [0:QBITS];
    logic [QBITS-1:0]  qy_reg   [0:QBITS];
    logic              ovfx_reg [0:QBITS];
    logic              ovfy_reg [0:QBITS];
    sign_t             sign_reg [0:QBITS];

    logic [NUM_W-1:0] numx;
    logic [NUM_W-1:0] numy;
    logic [CMP_W-1:0] den_top;

    always_comb begin
        numx    = NUM_W'(in_px) << FRAC_SHIFT;
        numy    = NUM_W'(in_py) << FRAC_SHIFT;
        den_top = CMP_W'(in_den) << QBITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0]  <= in_den;
            remx_reg[0] <= numx;
            remy_reg[0] <= numy;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            ovfx_reg[0] <= (CMP_W'(numx) >= den_top);
            ovfy_reg[0] <= (CMP_W'(numy) >= den_top);
            sign_reg[0] <= in_sign;
        end
    end

    for (genvar j = 0; j < QBITS; j++) begin : g_bit
        localparam int B = QBITS - 1 - j;
        logic [CMP_W-1:0] shifted;
        logic             takex;
        logic             takey;

        always_comb begin
            shifted = CMP_W'(den_reg[j]) << B;
            takex   = (CMP_W'(remx_reg[j]) >= shifted);
            takey   = (CMP_W'(remy_reg[j]) >= shifted);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[j+1]  <= den_reg[j];
                remx_reg[j+1] <= takex ? (remx_reg[j] - shifted[NUM_W-1:0]) : remx_reg[j];
                remy_reg[j+1] <= takey ? (remy_reg[j] - shifted[NUM_W-1:0]) : remy_reg[j];
                qx_reg[j+1]   <= qx_reg[j] | (QBITS'(takex) << B);
                qy_reg[j+1]   <= qy_reg[j] | (QBITS'(takey) << B);
                ovfx_reg[j+1] <= ovfx_reg[j];
                ovfy_reg[j+1] <= ovfy_reg[j];
                sign_reg[j+1] <= sign_reg[j];
            end
        end
    end

    logic [COORD_W-1:0] magx;
    logic [COORD_W-1:0] magy;
    sign_t              fin;

    always_comb begin
        fin  = sign_reg[QBITS];
        magx = {1'b0, qx_reg[QBITS]};
        magy = {1'b0, qy_reg[QBITS]};
        if (fin.coinc) begin
            accel_x = '0;
        end else if (ovfx_reg[QBITS]) begin
            accel_x = fin.nx ? SAT_NEG : SAT_POS;
        end else begin
            accel_x = fin.nx ? (COORD_W'(0) - magx) : magx;
        end
        if (fin.coinc) begin
            accel_y = '0;
        end else if (ovfy_reg[QBITS]) begin
            accel_y = fin.ny ? SAT_NEG : SAT_POS;
        end else begin
            accel_y = fin.ny ? (COORD_W'(0) - magy) : magy;
        end
    end

    assign coincident = fin.coinc;
    assign out_valid  = vld_reg[QBITS];

endmodule

@@ rtl/pairwise_gravity_accel.sv @@
// ----------------------------------------------------------------------------
// pairwise_gravity_accel
// Acceleration of one body toward another, G*m*d/|d|^3, signed Q16.16.
// ----------------------------------------------------------------------------
// One body pair is taken every clock cycle unless the result side stalls.
// The pipeline is built around the square root (one root bit per stage,
// 34 stages) and the two-lane divider (one quotient bit per stage plus
// an overflow stage), with offset, square, sum and three multiply stages
// around them. A stall on the result side holds the whole pipeline.
module pairwise_gravity_accel
    import pga_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [GRAV_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // self_x, self_y, other_x, other_y, other_mass
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // accel_x, accel_y
    output logic [2*COORD_W-1:0] m_tdata,
    // coincident
    output logic                 m_tuser
);

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [GRAV_W-1:0] grav_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg <= GRAV_RESET;
        end else if (cfg_we) begin
            grav_reg <= cfg_wdata;
        end
    end

    logic [COORD_W-1:0] self_x, self_y, other_x, other_y;
    logic [MASS_W-1:0]  other_mass;
    logic [MAG_W-1:0]   dx, dy;
    side_t              side_next;

    always_comb begin
        self_x     = s_tdata[COORD_W-1:0];
        self_y     = s_tdata[2*COORD_W-1:COORD_W];
        other_x    = s_tdata[3*COORD_W-1:2*COORD_W];
        other_y    = s_tdata[4*COORD_W-1:3*COORD_W];
        other_mass = s_tdata[IN_W-1:4*COORD_W];
        dx = {other_x[COORD_W-1], other_x} - {self_x[COORD_W-1], self_x};
        dy = {other_y[COORD_W-1], other_y} - {self_y[COORD_W-1], self_y};
        side_next.nx    = dx[MAG_W-1];
        side_next.ny    = dy[MAG_W-1];
        side_next.mx    = dx[MAG_W-1] ? (MAG_W'(0) - dx) : dx;
        side_next.my    = dy[MAG_W-1] ? (MAG_W'(0) - dy) : dy;
        side_next.coinc = (dx == '0) && (dy == '0);
        side_next.gm    = GM_W'(grav_reg) * GM_W'(other_mass);
    end

    logic             v1_reg, v2_reg, v3_reg;
    side_t            side1_reg, side2_reg, side3_reg;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg;
    logic [SUM_W-1:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= side_next;
            sqx_reg   <= SQ_W'(side1_reg.mx) * SQ_W'(side1_reg.mx);
            sqy_reg   <= SQ_W'(side1_reg.my) * SQ_W'(side1_reg.my);
            side2_reg <= side1_reg;
            sum_reg   <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
            side3_reg <= side2_reg;
        end
    end

    logic              sq_valid;
    logic [ROOT_W-1:0] root;
    side_t             sq_side;

    pga_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_sum    (sum_reg),
        .in_side   (side3_reg),
        .out_valid (sq_valid),
        .out_root  (root),
        .out_side  (sq_side)
    );

    logic              m1_reg, m2_reg, m3_reg;
    logic [R2_W-1:0]   r2_reg, lo_reg, hi_reg;
    logic [ROOT_W-1:0] root1_reg;
    logic [PROD_W-1:0] px1_reg, py1_reg, px2_reg, py2_reg, px3_reg, py3_reg;
    sign_t             sg1_reg, sg2_reg, sg3_reg;
    logic [DEN_W-1:0]  den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_reg <= 1'b0;
            m2_reg <= 1'b0;
            m3_reg <= 1'b0;
        end else if (en) begin
            m1_reg <= sq_valid;
            m2_reg <= m1_reg;
            m3_reg <= m2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r2_reg    <= R2_W'(root) * R2_W'(root);
            root1_reg <= root;
            px1_reg   <= PROD_W'(sq_side.gm) * PROD_W'(sq_side.mx);
            py1_reg   <= PROD_W'(sq_side.gm) * PROD_W'(sq_side.my);
            sg1_reg   <= '{nx: sq_side.nx, ny: sq_side.ny, coinc: sq_side.coinc};
            lo_reg    <= R2_W'(r2_reg[ROOT_W-1:0]) * R2_W'(root1_reg);
            hi_reg    <= R2_W'(r2_reg[R2_W-1:ROOT_W]) * R2_W'(root1_reg);
            px2_reg   <= px1_reg;
            py2_reg   <= py1_reg;
            sg2_reg   <= sg1_reg;
            den_reg   <= (DEN_W'(hi_reg) << ROOT_W) + DEN_W'(lo_reg);
            px3_reg   <= px2_reg;
            py3_reg   <= py2_reg;
            sg3_reg   <= sg2_reg;
        end
    end

    logic [COORD_W-1:0] accel_x, accel_y;

    pga_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (m3_reg),
        .in_den     (den_reg),
        .in_px      (px3_reg),
        .in_py      (py3_reg),
        .in_sign    (sg3_reg),
        .out_valid  (m_tvalid),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .coincident (m_tuser)
    );

    assign m_tdata = {accel_y, accel_x};

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_coincident_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("coincident result carries nonzero acceleration");

    a_empty_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule
